### rtl/hwc_pkg.sv
// hwc_pkg: shared types and constants of the heartbeat watchdog classifier
`timescale 1ns / 1ps

package hwc_pkg;

  localparam int OUT_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_EMERGENCY_DELAY = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_HOLDOFF   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_PERIOD   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MESSAGE_PERIOD  = 4'd3;

  localparam logic [CFG_W-1:0] EMERGENCY_DELAY_RST = 32'd2000;
  localparam logic [CFG_W-1:0] RESET_HOLDOFF_RST   = 32'd5000;
  localparam logic [CFG_W-1:0] NORMAL_PERIOD_RST   = 32'd1000;
  localparam logic [CFG_W-1:0] MESSAGE_PERIOD_RST  = 32'd500;

  typedef struct packed {
    logic [CFG_W-1:0] emergency_delay;
    logic [CFG_W-1:0] reset_holdoff;
    logic [CFG_W-1:0] normal_period;
    logic [CFG_W-1:0] message_period;
  } cfg_t;

  typedef struct packed {
    logic             reset_request;
    logic             rising_edge;
    logic             period_valid;
    logic [OUT_W-1:0] period_ticks;
    logic             period_class;
  } result_t;

endpackage

### rtl/hwc_core.sv
// hwc_core: tick counters, edge detect, period classification and reset decision
`timescale 1ns / 1ps

module hwc_core #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             level,
  input  hwc_pkg::cfg_t    cfg,
  output hwc_pkg::result_t result
);

  localparam int CMP_W = (TIME_BITS > hwc_pkg::OUT_W) ? TIME_BITS : hwc_pkg::OUT_W;

  logic                 previous_level;
  logic                 edge_seen;
  logic [TIME_BITS-1:0] ticks_since_edge;
  logic [TIME_BITS-1:0] ticks_since_reset;

  logic                 previous_level_next;
  logic                 edge_seen_next;
  logic [TIME_BITS-1:0] ticks_since_edge_next;
  logic [TIME_BITS-1:0] ticks_since_reset_next;

  logic [TIME_BITS-1:0] edge_inc;
  logic [TIME_BITS-1:0] reset_inc;
  logic [CMP_W-1:0]     period_wide;
  logic [hwc_pkg::OUT_W-1:0] period;
  logic [hwc_pkg::OUT_W-1:0] diff_normal;
  logic [hwc_pkg::OUT_W-1:0] diff_message;
  logic                 rise;
  logic                 req;

  always_comb begin
    // saturating advance of both counters
    edge_inc  = (&ticks_since_edge)  ? ticks_since_edge  : ticks_since_edge + 1'b1;
    reset_inc = (&ticks_since_reset) ? ticks_since_reset : ticks_since_reset + 1'b1;

    rise = level & ~previous_level;

    period_wide = CMP_W'(edge_inc);
    if (period_wide > CMP_W'({hwc_pkg::OUT_W{1'b1}})) begin
      period = {hwc_pkg::OUT_W{1'b1}};
    end else begin
      period = period_wide[hwc_pkg::OUT_W-1:0];
    end

    diff_normal  = (period >= cfg.normal_period) ? period - cfg.normal_period
                                                 : cfg.normal_period - period;
    diff_message = (period >= cfg.message_period) ? period - cfg.message_period
                                                   : cfg.message_period - period;

    ticks_since_edge_next = rise ? '0 : edge_inc;
    edge_seen_next        = edge_seen | rise;
    previous_level_next   = level;

    // edge tick leaves the edge counter at zero, so no request then
    req = (CMP_W'(ticks_since_edge_next) > CMP_W'(cfg.emergency_delay)) &&
          (CMP_W'(reset_inc) > CMP_W'(cfg.reset_holdoff));
    ticks_since_reset_next = req ? '0 : reset_inc;

    result.reset_request = req;
    result.rising_edge   = rise;
    result.period_valid  = rise & edge_seen;
    result.period_ticks  = (rise & edge_seen) ? period : '0;
    result.period_class  = rise & edge_seen & ~(diff_normal < diff_message);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level    <= 1'b0;
      edge_seen         <= 1'b0;
      ticks_since_edge  <= '0;
      ticks_since_reset <= '0;
    end else if (step) begin
      previous_level    <= previous_level_next;
      edge_seen         <= edge_seen_next;
      ticks_since_edge  <= ticks_since_edge_next;
      ticks_since_reset <= ticks_since_reset_next;
    end
  end

endmodule

### rtl/heartbeat_watchdog_classifier_top.sv
// heartbeat_watchdog_classifier_top: handshake, configuration registers and result register
`timescale 1ns / 1ps

// usage
// each input item is one tick carrying the sampled heartbeat level (in_valid / in_stall);
// each tick gives exactly one result item (out_valid / out_stall) with the reset
// request, rising edge flag and the measured, classified period
// configuration: cfg_valid with cfg_index / cfg_data, cfg_ready is always high;
// index 0 emergency delay, 1 reset holdoff, 2 normal period, 3 message period,
// any other index is ignored; write only while no item is in flight
// an accepted item goes into the input register, then through one pass of counter and
// compare logic into the result register, from which it is offered on out_valid
// throughput: one item per cycle while out_stall does not hold a full result register
// stall: when out_stall holds a full result register the input register keeps its
// item and in_stall rises; with both stages full nothing is lost or repeated
// reset: rst clears counters, edge history and both valid flags, and loads the
// register reset values (2000, 5000, 1000, 500)
module heartbeat_watchdog_classifier_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           heartbeat_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           reset_request,
  output logic                           rising_edge,
  output logic                           period_valid,
  output logic [hwc_pkg::OUT_W-1:0]      period_ticks,
  output logic                           period_class,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hwc_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [hwc_pkg::CFG_W-1:0]      cfg_data
);

  hwc_pkg::cfg_t    cfg;
  hwc_pkg::result_t step_result;
  hwc_pkg::result_t result;

  logic in_held;
  logic in_level;
  logic advance;
  logic in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.emergency_delay <= hwc_pkg::EMERGENCY_DELAY_RST;
      cfg.reset_holdoff   <= hwc_pkg::RESET_HOLDOFF_RST;
      cfg.normal_period   <= hwc_pkg::NORMAL_PERIOD_RST;
      cfg.message_period  <= hwc_pkg::MESSAGE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hwc_pkg::REG_EMERGENCY_DELAY: cfg.emergency_delay <= cfg_data;
        hwc_pkg::REG_RESET_HOLDOFF:   cfg.reset_holdoff   <= cfg_data;
        hwc_pkg::REG_NORMAL_PERIOD:   cfg.normal_period   <= cfg_data;
        hwc_pkg::REG_MESSAGE_PERIOD:  cfg.message_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register moves when empty or taken
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = in_held & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_take) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level <= heartbeat_level;
    end
  end

  hwc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (in_held & advance),
    .level  (in_level),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_held;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_held) begin
      result <= step_result;
    end
  end

  assign reset_request = result.reset_request;
  assign rising_edge   = result.rising_edge;
  assign period_valid  = result.period_valid;
  assign period_ticks  = result.period_ticks;
  assign period_class  = result.period_class;

endmodule

### rtl/hwc_checker.sv
// hwc_checker: port-level assertions for the heartbeat watchdog classifier, bound to the top
`timescale 1ns / 1ps

module hwc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      reset_request,
  input logic                      rising_edge,
  input logic                      period_valid,
  input logic [hwc_pkg::OUT_W-1:0] period_ticks,
  input logic                      period_class
);

  // an edge tick clears the edge counter, so it never requests a reset
  a_no_req_on_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reset_request && rising_edge))
    else $error("reset request on a rising edge item");

  a_period_needs_edge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && period_valid) |-> rising_edge)
    else $error("period reported without a rising edge");

  a_no_period_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !period_valid) |-> (period_ticks == '0 && !period_class))
    else $error("period fields set on an item without a period");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(reset_request) &&
      $stable(rising_edge) && $stable(period_valid) && $stable(period_ticks) &&
      $stable(period_class)))
    else $error("stalled result item changed");

endmodule

bind heartbeat_watchdog_classifier_top hwc_checker u_hwc_checker (.*);

### dv/hwc_period_checker.sv
// hwc_period_checker: watches the heartbeat watchdog channels, predicts each tick and compares
`timescale 1ns / 1ps

module hwc_period_checker #(
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           heartbeat_level,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           reset_request,
  input  logic                           rising_edge,
  input  logic                           period_valid,
  input  logic [hwc_pkg::OUT_W-1:0]      period_ticks,
  input  logic                           period_class,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hwc_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [hwc_pkg::CFG_W-1:0]      cfg_data,
  output int                             fail_count,
  output int                             pending
);

  localparam logic [63:0] PERIOD_MAX = 64'hFFFF_FFFF;

  logic [TIME_BITS-1:0] since_edge;
  logic [TIME_BITS-1:0] since_reset;
  logic                 prev_level;
  logic                 had_edge;
  hwc_pkg::cfg_t        wd_cfg;
  hwc_pkg::result_t     expected_ticks[$];
  int                   mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [hwc_pkg::OUT_W-1:0] distance(
    input logic [hwc_pkg::OUT_W-1:0] a,
    input logic [hwc_pkg::OUT_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // advances the watchdog state by one tick and returns the result it gives
  function hwc_pkg::result_t classify_tick(input logic level);
    hwc_pkg::result_t          r;
    logic [63:0]               wide;
    logic [hwc_pkg::OUT_W-1:0] d_normal;
    logic [hwc_pkg::OUT_W-1:0] d_message;
    r = '0;
    since_edge  = sat_inc(since_edge);
    since_reset = sat_inc(since_reset);
    if (level && !prev_level) begin
      r.rising_edge = 1'b1;
      if (had_edge) begin
        wide = 64'(since_edge);
        r.period_valid = 1'b1;
        r.period_ticks = (wide > PERIOD_MAX) ? '1 : wide[hwc_pkg::OUT_W-1:0];
        d_normal  = distance(r.period_ticks, wd_cfg.normal_period);
        d_message = distance(r.period_ticks, wd_cfg.message_period);
        // a tie goes to message pending
        r.period_class = (d_normal < d_message) ? 1'b0 : 1'b1;
      end
      since_edge = '0;
      had_edge   = 1'b1;
    end
    prev_level = level;
    if (since_edge > wd_cfg.emergency_delay && since_reset > wd_cfg.reset_holdoff) begin
      r.reset_request = 1'b1;
      since_reset     = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hwc_pkg::result_t got;
    hwc_pkg::result_t want;
    if (rst) begin
      since_edge  = '0;
      since_reset = '0;
      prev_level  = 1'b0;
      had_edge    = 1'b0;
      wd_cfg      = hwc_pkg::cfg_t'{hwc_pkg::EMERGENCY_DELAY_RST, hwc_pkg::RESET_HOLDOFF_RST,
                                    hwc_pkg::NORMAL_PERIOD_RST, hwc_pkg::MESSAGE_PERIOD_RST};
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hwc_pkg::REG_EMERGENCY_DELAY: wd_cfg.emergency_delay = cfg_data;
          hwc_pkg::REG_RESET_HOLDOFF:   wd_cfg.reset_holdoff   = cfg_data;
          hwc_pkg::REG_NORMAL_PERIOD:   wd_cfg.normal_period   = cfg_data;
          hwc_pkg::REG_MESSAGE_PERIOD:  wd_cfg.message_period  = cfg_data;
          default: ;
        endcase
      end
      // pop before push so a stray result never pairs with this edge's item
      if (out_valid && !out_stall) begin
        got.reset_request = reset_request;
        got.rising_edge   = rising_edge;
        got.period_valid  = period_valid;
        got.period_ticks  = period_ticks;
        got.period_class  = period_class;
        if (expected_ticks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with nothing expected:", $realtime,
                     " req=%0b edge=%0b valid=%0b ticks=%0d class=%0b",
                     got.reset_request, got.rising_edge, got.period_valid,
                     got.period_ticks, got.period_class);
        end else begin
          want = expected_ticks.pop_front();
          if (got.reset_request !== want.reset_request ||
              got.rising_edge   !== want.rising_edge   ||
              got.period_valid  !== want.period_valid  ||
              got.period_ticks  !== want.period_ticks  ||
              got.period_class  !== want.period_class) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected", $realtime,
                       " req=%0b edge=%0b valid=%0b ticks=%0d class=%0b,",
                       want.reset_request, want.rising_edge, want.period_valid,
                       want.period_ticks, want.period_class,
                       " got req=%0b edge=%0b valid=%0b ticks=%0d class=%0b",
                       got.reset_request, got.rising_edge, got.period_valid,
                       got.period_ticks, got.period_class);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_ticks.push_back(classify_tick(heartbeat_level));
    end
    fail_count <= mismatches;
    pending    <= expected_ticks.size();
  end

endmodule

### dv/tb.sv
// tb: stimulus, stall patterns and verdict for the heartbeat watchdog classifier
`timescale 1ns / 1ps

module tb;

  localparam int TIME_BITS       = 32;
  localparam int CLK_PERIOD      = 12;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 64;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_PHASES      = 8;

  localparam logic [hwc_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 4'hF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           heartbeat_level = 1'b0;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [hwc_pkg::CFG_ADDR_W-1:0] cfg_index = '0;
  logic [hwc_pkg::CFG_W-1:0]      cfg_data = '0;

  logic                      in_stall;
  logic                      out_valid;
  logic                      reset_request;
  logic                      rising_edge;
  logic                      period_valid;
  logic [hwc_pkg::OUT_W-1:0] period_ticks;
  logic                      period_class;
  logic                      cfg_ready;

  int            fail_count;
  int            pending;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            hold_left = 0;
  int            cycle_cnt = 0;
  logic          hold_token = 1'b0;
  logic          hold_seen = 1'b0;
  hwc_pkg::cfg_t cur_cfg;

  heartbeat_watchdog_classifier_top #(
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .heartbeat_level(heartbeat_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .reset_request(reset_request), .rising_edge(rising_edge),
    .period_valid(period_valid), .period_ticks(period_ticks),
    .period_class(period_class),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hwc_period_checker #(
    .TIME_BITS(TIME_BITS)
  ) period_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .heartbeat_level(heartbeat_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .reset_request(reset_request), .rising_edge(rising_edge),
    .period_valid(period_valid), .period_ticks(period_ticks),
    .period_class(period_class),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off each time the token flips
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    heartbeat_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // bits go out msb first
  task automatic send_bits(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hwc_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [hwc_pkg::CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_cfg(input hwc_pkg::cfg_t c, input logic with_stray);
    write_reg(hwc_pkg::REG_EMERGENCY_DELAY, c.emergency_delay);
    write_reg(hwc_pkg::REG_RESET_HOLDOFF, c.reset_holdoff);
    write_reg(hwc_pkg::REG_NORMAL_PERIOD, c.normal_period);
    write_reg(hwc_pkg::REG_MESSAGE_PERIOD, c.message_period);
    if (with_stray) write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic hwc_pkg::cfg_t rand_small_cfg();
    return hwc_pkg::cfg_t'{32'($urandom_range(0, 24)), 32'($urandom_range(0, 40)),
                           32'($urandom_range(2, 16)), 32'($urandom_range(2, 16))};
  endfunction

  task automatic set_mode(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct <= 0;  end
      IDLE_SEND: begin send_idle_pct = 84; stall_pct <= 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct <= 84; end
      default:   begin send_idle_pct = 20; stall_pct <= 20; end
    endcase
  endtask

  // mostly clean heartbeat pulses near the configured periods, some noise and quiet spells
  task automatic send_wave(input int n);
    int     sent;
    int     kind;
    int     len;
    int     tgt;
    int     high;
    longint base;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        len = $urandom_range(1, 6);
        repeat (len) send_tick(1'($urandom_range(1)));
        sent += len;
      end else if (kind == 2) begin
        len = (cur_cfg.emergency_delay <= 40) ?
              $urandom_range(1, int'(cur_cfg.emergency_delay) + 10) : $urandom_range(1, 30);
        repeat (len) send_tick(1'b0);
        sent += len;
      end else begin
        case ($urandom_range(2))
          0:       base = longint'(cur_cfg.normal_period);
          1:       base = longint'(cur_cfg.message_period);
          default: base = (longint'(cur_cfg.normal_period) +
                           longint'(cur_cfg.message_period)) / 2;
        endcase
        if (base < 2 || base > 40) base = $urandom_range(2, 40);
        tgt = int'(base) + int'($urandom_range(2)) - 1;
        if (tgt < 2) tgt = 2;
        high = $urandom_range(1, tgt - 1);
        repeat (tgt - high) send_tick(1'b0);
        repeat (high) send_tick(1'b1);
        sent += tgt;
      end
    end
  endtask

  initial begin
    hwc_pkg::cfg_t c;
    cur_cfg = hwc_pkg::cfg_t'{hwc_pkg::EMERGENCY_DELAY_RST, hwc_pkg::RESET_HOLDOFF_RST,
                              hwc_pkg::NORMAL_PERIOD_RST, hwc_pkg::MESSAGE_PERIOD_RST};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: first edge without a period, then short periods, a held-high level
    set_mode(IDLE_NONE);
    send_bits(32'b0110_0101, 8);
    drain;

    // small limits: requests while quiet, none on an edge tick, a tie, each class
    apply_cfg(hwc_pkg::cfg_t'{32'd2, 32'd3, 32'd4, 32'd2}, 1'b1);
    send_bits(32'b0000_1001_0100_0000, 16);
    drain;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       c = hwc_pkg::cfg_t'{32'd0, 32'd0, 32'd0, 32'd0};
        1:       c = hwc_pkg::cfg_t'{'1, '1, 32'd0, '1};
        2:       c = hwc_pkg::cfg_t'{32'd0, '1, '1, 32'd0};
        6:       c = hwc_pkg::cfg_t'{32'($urandom), 32'($urandom),
                                     32'($urandom), 32'($urandom)};
        default: c = rand_small_cfg();
      endcase
      apply_cfg(c, p == 3);
      set_mode(idle_mode_t'(p % 4));
      if (p == 4) begin
        // result side holds off while items keep coming, so the input backs up
        send_wave(ITEMS_PER_PHASE / 2);
        hold_token <= ~hold_token;
        send_wave(ITEMS_PER_PHASE / 2);
      end else if (p == 5) begin
        send_wave(ITEMS_PER_PHASE / 2);
        drain;
        send_wave(ITEMS_PER_PHASE / 2);
      end else begin
        send_wave(ITEMS_PER_PHASE);
      end
      drain;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
